// ===== rtl/lhfpa_pkg.sv =====
// Package for the LED hue fade and pulse animator.
// Holds fixed-point constants, code enums and the per-pixel control struct.
// Used by lhfpa_hsv2rgb and led_hue_fade_pulse_animator_unit.
package lhfpa_pkg;

	localparam int PIXELS_DEF = 11;

	localparam logic [18:0] HUE_FULL    = 19'd460800;
	localparam logic [18:0] HUE_MAX     = 19'd524287;
	localparam logic [16:0] HUE_SECTOR  = 17'd76800;
	localparam logic [15:0] BRIGHT_FULL = 16'd64000;
	localparam logic [21:0] FADE_STEP   = 22'd51200;
	localparam logic [24:0] NUM_FULL    = 25'd19584000;
	localparam logic [23:0] RECIP_M     = 24'd14660156;

	localparam logic [18:0] SECTOR_BASE [6] = '{
		19'd0, 19'd76800, 19'd153600, 19'd230400, 19'd307200, 19'd384000
	};

	localparam logic [7:0] CFG_HUE_STEP  = 8'd0;
	localparam logic [7:0] CFG_GLOW_STEP = 8'd1;
	localparam logic [7:0] CFG_GLOW_TINT = 8'd2;
	localparam logic [7:0] CFG_GLOW_SAT  = 8'd3;

	localparam logic [7:0] PRESET_FADE  = 8'd1;
	localparam logic [7:0] PRESET_PULSE = 8'd2;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_PRESET = 1'b1;

	typedef enum logic [1:0] {
		MODE_FROZEN = 2'd0,
		MODE_FADE   = 2'd1,
		MODE_PULSE  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_KEEP      = 2'd0,
		OP_ADVANCE   = 2'd1,
		OP_SET_FADE  = 2'd2,
		OP_SET_PULSE = 2'd3
	} hue_op_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic        last;
		logic [7:0]  sat;
		logic [15:0] bright;
	} pix_ctl_t;

endpackage

// ===== rtl/lhfpa_hsv2rgb.sv =====
// HSV to RGB conversion pipeline, four stages ending in the output register.
// Each channel is floor(bright * num / (64000 * 76800)) via a reciprocal multiply.
// Depends on lhfpa_pkg.
module lhfpa_hsv2rgb import lhfpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [18:0] in_hue,
	input  pix_ctl_t    in_ctl,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last
);

	logic        adv;
	logic        out_valid_q;

	logic [18:0] h_disp;
	logic [2:0]  sec;
	logic [18:0] f_wide;
	logic [16:0] f;
	logic [16:0] fc;

	logic        valid_s2;
	logic [2:0]  sec_s2;
	logic [24:0] sf_s2;
	logic [24:0] sfc_s2;
	logic [24:0] sp_s2;
	pix_ctl_t    ctl_s2;

	logic [24:0] nv;
	logic [24:0] np;
	logic [24:0] nq;
	logic [24:0] nt;
	logic [24:0] nr;
	logic [24:0] ng;
	logic [24:0] nb;

	logic        valid_s3;
	logic [24:0] nr_s3;
	logic [24:0] ng_s3;
	logic [24:0] nb_s3;
	pix_ctl_t    ctl_s3;

	logic [40:0] pr;
	logic [40:0] pg;
	logic [40:0] pb;

	logic        valid_s4;
	logic [21:0] xr_s4;
	logic [21:0] xg_s4;
	logic [21:0] xb_s4;
	pix_ctl_t    ctl_s4;

	logic [45:0] yr;
	logic [45:0] yg;
	logic [45:0] yb;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign out_valid = out_valid_q;

	always_comb begin
		h_disp = (in_hue >= HUE_FULL) ? 19'd0 : in_hue;
		sec = 3'd0;
		for (int k = 1; k < 6; k++) begin
			if (h_disp >= SECTOR_BASE[k]) begin
				sec = 3'(k);
			end
		end
		f_wide = h_disp - SECTOR_BASE[sec];
		f      = f_wide[16:0];
		fc     = HUE_SECTOR - f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s2 <= sec;
			sf_s2  <= 25'(in_ctl.sat) * 25'(f);
			sfc_s2 <= 25'(in_ctl.sat) * 25'(fc);
			sp_s2  <= 25'(in_ctl.sat) * 25'(HUE_SECTOR);
			ctl_s2 <= in_ctl;
		end
	end

	always_comb begin
		nv = NUM_FULL;
		np = NUM_FULL - sp_s2;
		nq = NUM_FULL - sf_s2;
		nt = NUM_FULL - sfc_s2;
		case (sec_s2)
			3'd0: begin
				nr = nv; ng = nt; nb = np;
			end
			3'd1: begin
				nr = nq; ng = nv; nb = np;
			end
			3'd2: begin
				nr = np; ng = nv; nb = nt;
			end
			3'd3: begin
				nr = np; ng = nq; nb = nv;
			end
			3'd4: begin
				nr = nt; ng = np; nb = nv;
			end
			default: begin
				nr = nv; ng = np; nb = nq;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s3  <= nr;
			ng_s3  <= ng;
			nb_s3  <= nb;
			ctl_s3 <= ctl_s2;
		end
	end

	assign pr = 41'(ctl_s3.bright) * 41'(nr_s3);
	assign pg = 41'(ctl_s3.bright) * 41'(ng_s3);
	assign pb = 41'(ctl_s3.bright) * 41'(nb_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xr_s4  <= pr[40:19];
			xg_s4  <= pg[40:19];
			xb_s4  <= pb[40:19];
			ctl_s4 <= ctl_s3;
		end
	end

	assign yr = 46'(xr_s4) * 46'(RECIP_M);
	assign yg = 46'(xg_s4) * 46'(RECIP_M);
	assign yb = 46'(xb_s4) * 46'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red         <= yr[44:37];
			green       <= yg[44:37];
			blue        <= yb[44:37];
			pixel_index <= ctl_s4.idx;
			last        <= ctl_s4.last;
		end
	end

endmodule

// ===== rtl/led_hue_fade_pulse_animator_unit.sv =====
// Top level of the LED hue fade and pulse animator.
// Holds the pixel hue memory, the shared animation state and the pixel walk.
// Depends on lhfpa_pkg and lhfpa_hsv2rgb.
//
// Usage:
//   Input channel (in_valid, in_stall, func, preset): func 0 is a tick that
//   advances the animation, func 1 latches a preset (1 fade, 2 pulse, other
//   freeze). Every transaction yields one frame of PIXELS colour results on
//   the output channel (out_valid, out_stall), pixels in order, last set on
//   the final one.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; indexes 0..3 are the hue step, the brightness step, the
//   pulse tint and the pulse saturation, others are dropped. Write only while idle.
//   Timing: one pixel is read from the hue memory, modified and written back
//   each cycle while the pipeline is not stalled; a new transaction is taken
//   only after the walk of the last one has ended. Each result passes the read
//   stage and the four converter stages on its way to the ports.
//   Stall: out_stall freezes the whole pixel pipeline and memory walk while a
//   result is valid, holding it on the ports. in_stall is high while a walk is going.
//   Reset: registers return to their defaults, all hues read as zero and
//   saturation and brightness are zero, so the first frame is black.
module led_hue_fade_pulse_animator_unit import lhfpa_pkg::*; #(
	parameter int PIXELS = PIXELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] preset,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] pixel_index,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int IW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	logic [7:0]  hue_step_q;
	logic [7:0]  glow_step_q;
	logic [7:0]  glow_tint_q;
	logic [7:0]  pulse_sat_q;

	mode_t       mode_q;
	logic [7:0]  sat_q;
	logic [15:0] bright_q;
	logic        ramp_up_q;
	hue_op_t     op_q;
	logic [18:0] hue_init_q;

	logic        issuing_q;
	logic [IW-1:0] cnt_q;

	logic [18:0] hue_mem [PIXELS];
	logic [PIXELS-1:0] hue_vld_q;

	logic        valid_s1;
	logic [IW-1:0] addr_s1;
	hue_op_t     op_s1;
	logic [18:0] init_s1;
	logic [18:0] hue_s1;
	pix_ctl_t    ctl_s1;

	logic        accept;
	logic        adv;
	logic        conv_stall;
	logic [19:0] pulse_mul;
	logic [18:0] pulse_h;
	logic [16:0] bsum;
	logic [21:0] fade_h;
	logic [19:0] adv_h;
	logic [18:0] new_hue;
	logic [IW+3:0] idx_ext;
	pix_ctl_t    ctl_issue;

	assign cfg_ready = 1'b1;
	assign in_stall  = issuing_q;
	assign accept    = in_valid && !issuing_q;
	assign adv       = !conv_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_step_q  <= 8'd128;
			glow_step_q <= 8'd64;
			glow_tint_q <= 8'd200;
			pulse_sat_q <= 8'd255;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HUE_STEP:  hue_step_q  <= cfg_data;
				CFG_GLOW_STEP: glow_step_q <= cfg_data;
				CFG_GLOW_TINT: glow_tint_q <= cfg_data;
				CFG_GLOW_SAT:  pulse_sat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pulse_mul = 20'(glow_tint_q) * 20'd3856;
		pulse_h   = 19'(glow_tint_q) * 19'd1807 + 19'(pulse_mul[19:16]);
		bsum      = {1'b0, bright_q} + 17'(glow_step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_FROZEN;
			sat_q      <= 8'd0;
			bright_q   <= 16'd0;
			ramp_up_q  <= 1'b0;
			op_q       <= OP_KEEP;
			hue_init_q <= 19'd0;
		end else if (accept) begin
			if (func == FUNC_PRESET) begin
				case (preset)
					PRESET_FADE: begin
						mode_q   <= MODE_FADE;
						sat_q    <= 8'd255;
						bright_q <= BRIGHT_FULL;
						op_q     <= OP_SET_FADE;
					end
					PRESET_PULSE: begin
						mode_q     <= MODE_PULSE;
						sat_q      <= pulse_sat_q;
						bright_q   <= 16'd0;
						ramp_up_q  <= 1'b0;
						hue_init_q <= pulse_h;
						op_q       <= OP_SET_PULSE;
					end
					default: begin
						mode_q <= MODE_FROZEN;
						op_q   <= OP_KEEP;
					end
				endcase
			end else begin
				case (mode_q)
					MODE_FADE: begin
						op_q <= OP_ADVANCE;
					end
					MODE_PULSE: begin
						op_q <= OP_KEEP;
						if (ramp_up_q) begin
							if (bsum >= 17'(BRIGHT_FULL)) begin
								bright_q  <= BRIGHT_FULL;
								ramp_up_q <= 1'b0;
							end else begin
								bright_q <= bsum[15:0];
							end
						end else if (bright_q <= 16'(glow_step_q)) begin
							bright_q  <= 16'd0;
							ramp_up_q <= 1'b1;
						end else begin
							bright_q <= bright_q - 16'(glow_step_q);
						end
					end
					default: begin
						op_q <= OP_KEEP;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			cnt_q     <= '0;
		end else if (accept) begin
			issuing_q <= 1'b1;
			cnt_q     <= '0;
		end else if (issuing_q && adv) begin
			if (cnt_q == IW'(PIXELS - 1)) begin
				issuing_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		fade_h = 22'(addr_s1) * FADE_STEP;
		adv_h  = {1'b0, hue_s1} + 20'(hue_step_q);
		case (op_s1)
			OP_ADVANCE:   new_hue = (adv_h >= 20'(HUE_FULL)) ? 19'd0 : adv_h[18:0];
			OP_SET_FADE:  new_hue = (fade_h > 22'(HUE_MAX)) ? HUE_MAX : fade_h[18:0];
			OP_SET_PULSE: new_hue = init_s1;
			default:      new_hue = hue_s1;
		endcase
	end

	always_comb begin
		idx_ext          = {4'b0, cnt_q};
		ctl_issue.idx    = idx_ext[3:0];
		ctl_issue.last   = (cnt_q == IW'(PIXELS - 1));
		ctl_issue.sat    = sat_q;
		ctl_issue.bright = bright_q;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			hue_mem[addr_s1] <= new_hue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_vld_q <= '0;
		end else if (adv && valid_s1) begin
			hue_vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issuing_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && issuing_q) begin
			if (valid_s1 && addr_s1 == cnt_q) begin
				hue_s1 <= new_hue;
			end else if (hue_vld_q[cnt_q]) begin
				hue_s1 <= hue_mem[cnt_q];
			end else begin
				hue_s1 <= 19'd0;
			end
			addr_s1 <= cnt_q;
			op_s1   <= op_q;
			init_s1 <= hue_init_q;
			ctl_s1  <= ctl_issue;
		end
	end

	lhfpa_hsv2rgb u_hsv2rgb (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.in_stall    (conv_stall),
		.in_hue      (new_hue),
		.in_ctl      (ctl_s1),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for led_hue_fade_pulse_animator_unit.
// An in-file scoreboard predicts each frame of pixel colours and checks it, field by field.
// Depends on lhfpa_pkg and the animator RTL.
module tb;
	import lhfpa_pkg::*;

	localparam int NPIX         = PIXELS_DEF;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_colour_t;

	class pixel_frame_scoreboard;
		logic [7:0]    hue_step, glow_step, glow_tint, pulse_sat;
		logic [18:0]   hue [NPIX];
		logic [7:0]    sat_now;
		logic [15:0]   bright;
		logic          ramp_up;
		mode_t         mode;
		pixel_colour_t expected_colours [$];
		int            fails;

		function new();
			hue_step  = 8'd128;
			glow_step = 8'd64;
			glow_tint = 8'd200;
			pulse_sat = 8'd255;
			foreach (hue[i]) hue[i] = '0;
			sat_now = '0;
			bright  = '0;
			ramp_up = 1'b0;
			mode    = MODE_FROZEN;
			fails   = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] data);
			case (idx)
				CFG_HUE_STEP:  hue_step  = data;
				CFG_GLOW_STEP: glow_step = data;
				CFG_GLOW_TINT: glow_tint = data;
				CFG_GLOW_SAT:  pulse_sat = data;
				default: ;
			endcase
		endfunction

		function rgb_t hsv_colour(logic [18:0] h_in);
			longint unsigned b, s, f, v, p, q, t, span, full;
			int unsigned h, sector;
			rgb_t c;
			b = bright;
			s = sat_now;
			span = HUE_SECTOR;
			full = BRIGHT_FULL;
			full = full * span;
			h = (h_in >= HUE_FULL) ? 0 : h_in;
			sector = h / HUE_SECTOR;
			f = h % HUE_SECTOR;
			v = (b * 255) / BRIGHT_FULL;
			p = (b * (255 - s)) / BRIGHT_FULL;
			q = (b * (255 * span - s * f)) / full;
			t = (b * (255 * span - s * (span - f))) / full;
			case (sector)
				0: c = '{v[7:0], t[7:0], p[7:0]};
				1: c = '{q[7:0], v[7:0], p[7:0]};
				2: c = '{p[7:0], v[7:0], t[7:0]};
				3: c = '{p[7:0], q[7:0], v[7:0]};
				4: c = '{t[7:0], p[7:0], v[7:0]};
				default: c = '{v[7:0], p[7:0], q[7:0]};
			endcase
			return c;
		endfunction

		function void note_transaction(logic f, logic [7:0] sel);
			int unsigned h;
			rgb_t c;
			pixel_colour_t e;
			if (f == FUNC_PRESET) begin
				if (sel == PRESET_FADE) begin
					mode = MODE_FADE;
					for (int i = 0; i < NPIX; i++) begin
						h = i * 40 * 1280;
						hue[i] = (h > HUE_MAX) ? HUE_MAX : h[18:0];
					end
					sat_now = 8'd255;
					bright  = BRIGHT_FULL;
				end else if (sel == PRESET_PULSE) begin
					h = (glow_tint * HUE_FULL) / 255;
					mode = MODE_PULSE;
					foreach (hue[i]) hue[i] = h[18:0];
					sat_now = pulse_sat;
					bright  = '0;
					ramp_up = 1'b0;
				end else begin
					mode = MODE_FROZEN;
				end
			end else if (mode == MODE_FADE) begin
				foreach (hue[i]) begin
					h = hue[i] + hue_step;
					hue[i] = (h >= HUE_FULL) ? '0 : h[18:0];
				end
			end else if (mode == MODE_PULSE) begin
				if (ramp_up) begin
					h = bright + glow_step;
					if (h >= BRIGHT_FULL) begin
						h = BRIGHT_FULL;
						ramp_up = 1'b0;
					end
					bright = h[15:0];
				end else if (bright <= glow_step) begin
					bright  = '0;
					ramp_up = 1'b1;
				end else begin
					bright = bright - glow_step;
				end
			end
			for (int i = 0; i < NPIX; i++) begin
				c = hsv_colour(hue[i]);
				e.idx   = i[3:0];
				e.red   = c.r;
				e.green = c.g;
				e.blue  = c.b;
				e.last  = (i == NPIX - 1);
				expected_colours.push_back(e);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s expected %0d actual %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_colour(logic [3:0] idx, logic [7:0] r, logic [7:0] g,
				logic [7:0] b, logic l);
			pixel_colour_t e;
			if (expected_colours.size() == 0) begin
				$error("unexpected colour transaction, pixel_index %0d", idx);
				fails++;
			end else begin
				e = expected_colours.pop_front();
				compare_field("pixel_index", 8'(e.idx), 8'(idx));
				compare_field("red", e.red, r);
				compare_field("green", e.green, g);
				compare_field("blue", e.blue, b);
				compare_field("last", 8'(e.last), 8'(l));
			end
		endfunction

		function int pending();
			return expected_colours.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       func;
	logic [7:0] preset;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] pixel_index;
	logic [7:0] red, green, blue;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_index;
	logic [7:0] cfg_data;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int          rx_hold = 0;
	int          cycles = 0;

	pixel_frame_scoreboard sb = new();

	led_hue_fade_pulse_animator_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.preset     (preset),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_index(pixel_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall = 1'b1;
			rx_hold--;
		end else begin
			out_stall = ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_colour(pixel_index, red, green, blue, last);
	end

	task automatic send_item(logic f, logic [7:0] sel);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func     = f;
		preset   = sel;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_transaction(f, sel);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(logic [7:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_registers(logic [7:0] fr, logic [7:0] pr, logic [7:0] ph,
			logic [7:0] ps);
		drain();
		cfg_write(CFG_HUE_STEP, fr);
		cfg_write(CFG_GLOW_STEP, pr);
		cfg_write(CFG_GLOW_TINT, ph);
		cfg_write(CFG_GLOW_SAT, ps);
	endtask

	// Preset first, then a run of ticks; a few presets pick an arbitrary code
	task automatic run_animation(int n_items);
		int sent;
		int unsigned pick;
		logic [7:0] sel;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 45)
				sel = PRESET_FADE;
			else if (pick < 90)
				sel = PRESET_PULSE;
			else
				sel = 8'($urandom_range(255));
			send_item(FUNC_PRESET, sel);
			sent++;
			repeat ($urandom_range(40, 1)) begin
				if (sent < n_items) begin
					send_item(FUNC_TICK, 8'($urandom_range(255)));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = FUNC_TICK;
		preset      = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		tx_idle_pct = 25;
		rx_idle_pct = 47;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// black frame from reset, then freeze, fade with wrapping hues, pulse turnaround
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_PRESET, 8'h00);
		send_item(FUNC_PRESET, PRESET_FADE);
		repeat (3) send_item(FUNC_TICK, 8'hFF);
		send_item(FUNC_PRESET, 8'hFF);
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_PRESET, PRESET_PULSE);
		repeat (3) send_item(FUNC_TICK, 8'h00);

		// zero saturation, zero rates, top pulse hue, stray register index
		set_registers(8'd0, 8'd0, 8'd255, 8'd0);
		cfg_write(8'hFF, 8'hFF);
		send_item(FUNC_PRESET, PRESET_PULSE);
		repeat (2) send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_PRESET, PRESET_FADE);
		send_item(FUNC_TICK, 8'h00);

		set_registers(8'd255, 8'd255, 8'd0, 8'd128);
		send_item(FUNC_PRESET, PRESET_PULSE);
		repeat (3) send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_PRESET, 8'd3);
		send_item(FUNC_TICK, 8'h00);

		// long pulse run: ramp to full, clamp and turn back down
		set_registers(8'd255, 8'd255, 8'($urandom_range(255)), 8'($urandom_range(255)));
		send_item(FUNC_PRESET, PRESET_PULSE);
		repeat (265) send_item(FUNC_TICK, 8'($urandom_range(255)));
		run_animation(25);

		drain();
		tx_idle_pct = 47;
		rx_idle_pct = 25;
		set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		cfg_write(8'($urandom_range(255, CFG_GLOW_SAT + 1)), 8'($urandom_range(255)));
		run_animation(30);

		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_registers(8'd1, 8'd1, 8'($urandom_range(255)), 8'd255);
		rx_hold = 400;
		run_animation(25);

		drain();
		repeat (40) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
